// ----- rtl/core/stt_pkg.sv -----
// Shared types and constants for the software timer table.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RESET = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_EXPIRY = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_ANSWER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ROT,
        ST_FIND
    } t_state;

    typedef enum logic [1:0] {
        UPD_PASS,
        UPD_TICK,
        UPD_RELOAD,
        UPD_CLEAR
    } t_upd_op;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [31:0] remaining;
        logic        repeat_en;
        logic        active;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ----- rtl/core/software_timer_table.sv -----
// Top level of the software timer table: cell chain, head update unit and sequencer.
// Add: one cycle, answer word on the cycle after start; busy stays low.
// Tick: occupancy+1 walk cycles then (SLOTS-kept)+1 realignment cycles; expiry words
//   appear during the walk, the last one at its end. Reset/clear: SLOTS cycles, answer after.
// One command at a time while busy is high; results are strobed for one cycle, no stall.
// Synchronous active-low reset empties the table and zeroes the handle counter.
`timescale 1ns / 1ps

module software_timer_table #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_delta,
    input  logic [31:0] i_period,
    input  logic        i_repeat_req,
    input  logic [31:0] i_target_handle,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [31:0] o_handle_out,
    output logic        o_ok,
    output logic        o_last
);

    localparam int W = $clog2(SLOTS + 1);
    localparam logic [W-1:0] SLOTS_W = W'(SLOTS);
    localparam logic [W-1:0] LAST_W  = W'(SLOTS - 1);

    stt_pkg::t_state r_state, n_state;
    logic [W-1:0]    r_occ, n_occ;
    logic [W-1:0]    r_cnt, n_cnt;
    logic [W-1:0]    r_kept, n_kept;
    logic [31:0]     r_hcnt, n_hcnt;
    stt_pkg::t_cmd   r_cmd, n_cmd;
    logic [31:0]     r_delta, n_delta;
    logic [31:0]     r_target, n_target;
    logic            r_found, n_found;
    logic            r_pend_v, n_pend_v;
    logic [31:0]     r_pend, n_pend;
    logic            r_out_v, n_out_v;
    logic [1:0]      r_out_kind, n_out_kind;
    logic [31:0]     r_out_handle, n_out_handle;
    logic            r_out_ok, n_out_ok;
    logic            r_out_last, n_out_last;

    stt_pkg::t_slot    cell_q [SLOTS];
    stt_pkg::t_slot    cell_next [SLOTS];
    stt_pkg::t_cell_ctl cell_ctl [SLOTS];
    stt_pkg::t_slot    load_slot;
    stt_pkg::t_slot    upd_slot;
    stt_pkg::t_upd_op  upd_op;
    logic              upd_in_range;
    logic              upd_keep;
    logic              upd_expired;
    logic              upd_match;
    logic              do_shift;
    logic              do_load;
    logic [W-1:0]      shift_lim;
    logic [31:0]       hcnt_inc;
    logic              accept;

    assign accept   = start && !busy;
    assign busy     = (r_state != stt_pkg::ST_IDLE);
    assign hcnt_inc = (r_hcnt + 32'd1 == 32'd0) ? 32'd1 : r_hcnt + 32'd1;

    always_comb begin
        load_slot.id        = hcnt_inc;
        load_slot.period    = i_period;
        load_slot.remaining = i_period;
        load_slot.repeat_en = i_repeat_req;
        load_slot.active    = 1'b1;
    end

    stt_upd u_upd (
        .i_op       (upd_op),
        .i_slot     (cell_q[0]),
        .i_in_range (upd_in_range),
        .i_found    (r_found),
        .i_delta    (r_delta),
        .i_target   (r_target),
        .o_slot     (upd_slot),
        .o_keep     (upd_keep),
        .o_expired  (upd_expired),
        .o_match    (upd_match)
    );

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == SLOTS - 1) begin : g_tail
            assign cell_next[g] = upd_slot;
        end else begin : g_body
            assign cell_next[g] = cell_q[g+1];
        end
        assign cell_ctl[g].shift = do_shift && (W'(g) < shift_lim);
        assign cell_ctl[g].load  = do_load && (r_occ == W'(g));

        stt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_next      (cell_next[g]),
            .i_load_slot (load_slot),
            .o_slot      (cell_q[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stt_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (stt_pkg::t_cmd'(i_cmd)) inside
                        stt_pkg::CMD_TICK:                     n_state = stt_pkg::ST_WALK;
                        stt_pkg::CMD_RESET, stt_pkg::CMD_CLEAR: n_state = stt_pkg::ST_FIND;
                        default:                               n_state = stt_pkg::ST_IDLE;
                    endcase
                end
            end
            stt_pkg::ST_WALK: begin
                if (r_cnt == r_occ) begin
                    n_state = stt_pkg::ST_ROT;
                end
            end
            stt_pkg::ST_ROT: begin
                if (r_cnt == SLOTS_W - r_kept) begin
                    n_state = stt_pkg::ST_IDLE;
                end
            end
            stt_pkg::ST_FIND: begin
                if (r_cnt == LAST_W) begin
                    n_state = stt_pkg::ST_IDLE;
                end
            end
            default: n_state = stt_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_occ        = r_occ;
        n_cnt        = r_cnt;
        n_kept       = r_kept;
        n_hcnt       = r_hcnt;
        n_cmd        = r_cmd;
        n_delta      = r_delta;
        n_target     = r_target;
        n_found      = r_found;
        n_pend_v     = r_pend_v;
        n_pend       = r_pend;
        n_out_v      = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_handle = r_out_handle;
        n_out_ok     = r_out_ok;
        n_out_last   = r_out_last;
        upd_op       = stt_pkg::UPD_PASS;
        upd_in_range = 1'b0;
        do_shift     = 1'b0;
        do_load      = 1'b0;
        shift_lim    = SLOTS_W;
        unique case (r_state)
            stt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd    = stt_pkg::t_cmd'(i_cmd);
                    n_delta  = i_delta;
                    n_target = i_target_handle;
                    n_cnt    = '0;
                    n_kept   = '0;
                    n_found  = 1'b0;
                    n_pend_v = 1'b0;
                    if (stt_pkg::t_cmd'(i_cmd) == stt_pkg::CMD_ADD) begin
                        n_out_v    = 1'b1;
                        n_out_kind = stt_pkg::KIND_ADD;
                        n_out_last = 1'b1;
                        if (r_occ >= SLOTS_W) begin
                            n_out_handle = 32'd0;
                            n_out_ok     = 1'b0;
                        end else begin
                            do_load      = 1'b1;
                            n_occ        = r_occ + W'(1);
                            n_hcnt       = hcnt_inc;
                            n_out_handle = hcnt_inc;
                            n_out_ok     = 1'b1;
                        end
                    end
                end
            end
            stt_pkg::ST_WALK: begin
                if (r_cnt == r_occ) begin
                    n_cnt = '0;
                    if (r_pend_v) begin
                        n_out_v      = 1'b1;
                        n_out_kind   = stt_pkg::KIND_EXPIRY;
                        n_out_handle = r_pend;
                        n_out_ok     = 1'b0;
                        n_out_last   = 1'b1;
                        n_pend_v     = 1'b0;
                    end
                end else begin
                    upd_op       = stt_pkg::UPD_TICK;
                    upd_in_range = 1'b1;
                    do_shift     = 1'b1;
                    n_cnt        = r_cnt + W'(1);
                    // kept slots gather at the tail; a dropped one only advances the front
                    if (upd_keep) begin
                        shift_lim = SLOTS_W;
                        n_kept    = r_kept + W'(1);
                    end else begin
                        shift_lim = SLOTS_W - r_kept;
                    end
                    if (upd_expired) begin
                        if (r_pend_v) begin
                            n_out_v      = 1'b1;
                            n_out_kind   = stt_pkg::KIND_EXPIRY;
                            n_out_handle = r_pend;
                            n_out_ok     = 1'b0;
                            n_out_last   = 1'b0;
                        end
                        n_pend   = cell_q[0].id;
                        n_pend_v = 1'b1;
                    end
                end
            end
            stt_pkg::ST_ROT: begin
                if (r_cnt == SLOTS_W - r_kept) begin
                    n_occ = r_kept;
                    n_cnt = '0;
                end else begin
                    do_shift = 1'b1;
                    n_cnt    = r_cnt + W'(1);
                end
            end
            stt_pkg::ST_FIND: begin
                upd_op       = (r_cmd == stt_pkg::CMD_RESET) ? stt_pkg::UPD_RELOAD
                                                             : stt_pkg::UPD_CLEAR;
                upd_in_range = (r_cnt < r_occ);
                do_shift     = 1'b1;
                n_cnt        = r_cnt + W'(1);
                if (upd_match) begin
                    n_found = 1'b1;
                end
                if (r_cnt == LAST_W) begin
                    n_cnt        = '0;
                    n_out_v      = 1'b1;
                    n_out_kind   = stt_pkg::KIND_ANSWER;
                    n_out_handle = 32'd0;
                    n_out_ok     = r_found || upd_match;
                    n_out_last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stt_pkg::ST_IDLE;
            r_occ    <= '0;
            r_cnt    <= '0;
            r_kept   <= '0;
            r_hcnt   <= 32'd0;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_cnt    <= n_cnt;
            r_kept   <= n_kept;
            r_hcnt   <= n_hcnt;
            r_found  <= n_found;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_delta      <= n_delta;
        r_target     <= n_target;
        r_pend       <= n_pend;
        r_out_kind   <= n_out_kind;
        r_out_handle <= n_out_handle;
        r_out_ok     <= n_out_ok;
        r_out_last   <= n_out_last;
    end

    assign o_valid      = r_out_v;
    assign o_kind       = r_out_kind;
    assign o_handle_out = r_out_handle;
    assign o_ok         = r_out_ok;
    assign o_last       = r_out_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= SLOTS_W)
        else $error("occupancy beyond table size");

    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != stt_pkg::KIND_EXPIRY) |-> o_last)
        else $error("command answer not marked last");

    a_add_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == stt_pkg::CMD_ADD) |=> o_valid && (o_kind == stt_pkg::KIND_ADD))
        else $error("add gave no answer");

    a_expiry_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == stt_pkg::KIND_EXPIRY) |-> $past(r_state) == stt_pkg::ST_WALK)
        else $error("expiry word outside tick walk");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stt_pkg::ST_ROT) |-> !r_pend_v)
        else $error("expiry left pending after walk");

endmodule

// ----- rtl/core/stt_cell.sv -----
// One timer cell of the chain: takes its neighbour's slot on shift, or a new slot on load.
`timescale 1ns / 1ps

module stt_cell (
    input  logic              i_clk,
    input  stt_pkg::t_cell_ctl i_ctl,
    input  stt_pkg::t_slot    i_next,
    input  stt_pkg::t_slot    i_load_slot,
    output stt_pkg::t_slot    o_slot
);

    stt_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_slot <= i_load_slot;
        end else if (i_ctl.shift) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- rtl/core/stt_upd.sv -----
// Update unit for the slot at the head of the chain: tick countdown, reload, clear, match.
`timescale 1ns / 1ps

module stt_upd (
    input  stt_pkg::t_upd_op i_op,
    input  stt_pkg::t_slot   i_slot,
    input  logic             i_in_range,
    input  logic             i_found,
    input  logic [31:0]      i_delta,
    input  logic [31:0]      i_target,
    output stt_pkg::t_slot   o_slot,
    output logic             o_keep,
    output logic             o_expired,
    output logic             o_match
);

    always_comb begin
        o_match = i_in_range && !i_found && (i_target != 32'd0) && (i_slot.id == i_target);
    end

    always_comb begin
        o_slot    = i_slot;
        o_keep    = 1'b1;
        o_expired = 1'b0;
        unique case (i_op)
            stt_pkg::UPD_PASS: begin
            end
            stt_pkg::UPD_TICK: begin
                if (!i_slot.active) begin
                    o_keep = 1'b0;
                end else if (i_delta >= i_slot.remaining) begin
                    o_expired = 1'b1;
                    if (i_slot.repeat_en) begin
                        o_slot.remaining = i_slot.period;
                    end else begin
                        o_slot.active = 1'b0;
                        o_keep        = 1'b0;
                    end
                end else begin
                    o_slot.remaining = i_slot.remaining - i_delta;
                end
            end
            stt_pkg::UPD_RELOAD: begin
                if (o_match) begin
                    o_slot.remaining = i_slot.period;
                end
            end
            stt_pkg::UPD_CLEAR: begin
                if (o_match) begin
                    o_slot.active = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
